// ----- hw/rtl/frame_rms_level_meter_top_macros.svh -----
// ----------------------------------------------------------------------------
// Frame RMS level meter assertion macros
// Shared property shorthands; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef FRAME_RMS_LEVEL_METER_TOP_MACROS_SVH
`define FRAME_RMS_LEVEL_METER_TOP_MACROS_SVH

// same-cycle implication
`define FRL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/frl_pkg.sv -----
// ----------------------------------------------------------------------------
// frl_pkg
// Shared widths, constants and types of the frame RMS level meter.
// ----------------------------------------------------------------------------
`default_nettype none

package frl_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 16;
    localparam int FLEN_W   = 10;
    localparam int THRESH_W = 16;

    // serial multiplier digit
    localparam int DIGIT_W = 4;

    // log2 mantissa and fraction widths
    localparam int MANT_W = 32;
    localparam int FRAC_W = 16;

    // 10*log10(2) in Q.24, rescaled so that a Q.16 log2 maps to Q8.8 dB after >> 32
    localparam int                K_W             = 26;
    localparam logic [K_W-1:0]    TEN_LOG10_2_Q24 = 26'd50504453;
    localparam int                ROUND_SHIFT     = 32;

    localparam logic [LEVEL_W-1:0]        FLOOR_MAG    = 16'd30720;
    localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR  = -16'sd30720;
    localparam logic signed [LEVEL_W-1:0] LEVEL_CEIL   = 16'sd0;
    localparam logic signed [THRESH_W-1:0] THRESH_RESET = -16'sd17920;

    typedef struct packed {
        logic start;
        logic clear;
    } acc_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/frl_channels.sv -----
// ----------------------------------------------------------------------------
// frl_channels
// Valid/ready channels of the level meter: samples, levels, configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface frl_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               end_of_frame;

    modport source (output valid, output sample, output end_of_frame, input ready);
    modport sink   (input valid, input sample, input end_of_frame, output ready);
endinterface

interface frl_level_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] level_db;
    logic               below_silence;
    logic [9:0]         frame_length;

    modport source (output valid, output level_db, output below_silence,
                    output frame_length, input ready);
    modport sink   (input valid, input level_db, input below_silence,
                    input frame_length, output ready);
endinterface

interface frl_cfg_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/frl_smul.sv -----
// ----------------------------------------------------------------------------
// frl_smul
// Digit-serial unsigned multiplier: one DIGIT_W digit of b per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module frl_smul
    import frl_pkg::*;
#(
    parameter int AW = 32,
    parameter int BW = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [AW+BW-1:0] p
);

    localparam int NDIG = (BW + DIGIT_W - 1) / DIGIT_W;
    localparam int BPW  = NDIG * DIGIT_W;
    localparam int PW   = AW + BPW;
    localparam int CW   = $clog2(NDIG + 1);
    localparam logic [CW-1:0] LAST = CW'(NDIG - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [AW-1:0]         a_reg, a_next;
    logic [BPW-1:0]        b_reg, b_next;
    logic [PW-1:0]         p_reg, p_next;
    logic [AW+DIGIT_W-1:0] part;

    assign part = {{DIGIT_W{1'b0}}, a_reg} * {{AW{1'b0}}, b_reg[BPW-1 -: DIGIT_W]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            b_next    = BPW'(b);
            p_next    = '0;
        end
        else if (busy_reg)
        begin
            // shift in the next partial product
            p_next   = (p_reg << DIGIT_W) + PW'(part);
            b_next   = b_reg << DIGIT_W;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign done = done_reg;
    assign p    = p_reg[AW+BW-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/frl_sqacc.sv -----
// ----------------------------------------------------------------------------
// frl_sqacc
// Squares one sample serially and adds it to the frame sum and sample count.
// ----------------------------------------------------------------------------
`default_nettype none

module frl_sqacc
    import frl_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 40,
    parameter int CNT_W       = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  acc_ctrl_t           ctrl,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                done,
    output logic [SUM_W-1:0]    sum,
    output logic [CNT_W-1:0]    count
);

    logic [SAMPLE_BITS-1:0]   word;
    logic [SAMPLE_BITS-1:0]   mag;
    logic                     sq_done;
    logic [2*SAMPLE_BITS-1:0] sq;

    logic             done_reg, done_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;

    generate
        if (SAMPLE_BITS <= SAMPLE_W)
        begin : g_narrow
            assign word = sample[SAMPLE_BITS-1:0];
        end
        else
        begin : g_wide
            assign word = SAMPLE_BITS'(sample);
        end
    endgenerate

    // the most negative code maps to 2^(SAMPLE_BITS-1), which still fits unsigned
    assign mag = word[SAMPLE_BITS-1] ? (~word + 1'b1) : word;

    frl_smul #(
        .AW (SAMPLE_BITS),
        .BW (SAMPLE_BITS)
    ) u_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.start),
        .a     (mag),
        .b     (mag),
        .done  (sq_done),
        .p     (sq)
    );

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        if (ctrl.clear)
        begin
            sum_next   = '0;
            count_next = '0;
        end
        else if (sq_done)
        begin
            sum_next   = sum_reg + SUM_W'(sq);
            count_next = count_reg + 1'b1;
            done_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            done_reg  <= done_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    assign done  = done_reg;
    assign sum   = sum_reg;
    assign count = count_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/frl_log2.sv -----
// ----------------------------------------------------------------------------
// frl_log2
// Q.16 log2 of a positive integer: serial normalize, then 16 squaring steps.
// ----------------------------------------------------------------------------
`default_nettype none

module frl_log2
    import frl_pkg::*;
#(
    parameter int XW = 40
)
(
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            start,
    input  logic [XW-1:0]                                   x,
    output logic                                            done,
    output logic [$clog2((XW > MANT_W) ? XW : MANT_W)+FRAC_W-1:0] result
);

    localparam int NW    = (XW > MANT_W) ? XW : MANT_W;
    localparam int PB_W  = $clog2(NW);
    localparam int IT_W  = $clog2(FRAC_W);
    localparam logic [IT_W-1:0] IT_LAST = IT_W'(FRAC_W - 1);

    localparam logic [1:0] LG_IDLE = 2'd0;
    localparam logic [1:0] LG_NORM = 2'd1;
    localparam logic [1:0] LG_SQ   = 2'd2;
    localparam logic [1:0] LG_WAIT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              done_reg, done_next;
    logic [NW-1:0]     norm_reg, norm_next;
    logic [PB_W-1:0]   p_reg, p_next;
    logic [MANT_W-1:0] m_reg, m_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [IT_W-1:0]   it_reg, it_next;

    logic                mul_start, mul_done;
    logic [2*MANT_W-1:0] prod;
    logic [MANT_W:0]     q;

    frl_smul #(
        .AW (MANT_W),
        .BW (MANT_W)
    ) u_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (m_reg),
        .b     (m_reg),
        .done  (mul_done),
        .p     (prod)
    );

    // (m*m) >> 31
    assign q = prod[2*MANT_W-1:MANT_W-1];

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        norm_next  = norm_reg;
        p_next     = p_reg;
        m_next     = m_reg;
        frac_next  = frac_reg;
        it_next    = it_reg;
        mul_start  = 1'b0;
        unique case (state_reg)
            LG_IDLE:
            begin
                if (start)
                begin
                    norm_next  = NW'(x);
                    p_next     = PB_W'(NW - 1);
                    state_next = LG_NORM;
                end
            end
            LG_NORM:
            begin
                // walk the leading one up to the top, one bit a cycle
                if (norm_reg[NW-1] || (p_reg == '0))
                begin
                    m_next     = norm_reg[NW-1 -: MANT_W];
                    frac_next  = '0;
                    it_next    = '0;
                    state_next = LG_SQ;
                end
                else
                begin
                    norm_next = norm_reg << 1;
                    p_next    = p_reg - 1'b1;
                end
            end
            LG_SQ:
            begin
                mul_start  = 1'b1;
                state_next = LG_WAIT;
            end
            LG_WAIT:
            begin
                if (mul_done)
                begin
                    // a square at or above 2 yields a one and halves the mantissa
                    if (q[MANT_W])
                    begin
                        m_next = q[MANT_W:1];
                    end
                    else
                    begin
                        m_next = q[MANT_W-1:0];
                    end
                    frac_next = {frac_reg[FRAC_W-2:0], q[MANT_W]};
                    if (it_reg == IT_LAST)
                    begin
                        done_next  = 1'b1;
                        state_next = LG_IDLE;
                    end
                    else
                    begin
                        it_next    = it_reg + 1'b1;
                        state_next = LG_SQ;
                    end
                end
            end
            default:
            begin
                state_next = LG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LG_IDLE;
            done_reg  <= 1'b0;
            it_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            it_reg    <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        norm_reg <= norm_next;
        p_reg    <= p_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
    end

    assign done   = done_reg;
    assign result = {p_reg, frac_reg};

endmodule

`default_nettype wire

// ----- hw/rtl/frl_level.sv -----
// ----------------------------------------------------------------------------
// frl_level
// Frame level in Q8.8 dB: log2(sum) - log2(n) - offset, scaled to dB, clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module frl_level
    import frl_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 40,
    parameter int CNT_W       = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM_W-1:0]   sum,
    input  logic [CNT_W-1:0]   count,
    output logic               done,
    output logic [LEVEL_W-1:0] level
);

    localparam int NW     = (SUM_W > MANT_W) ? SUM_W : MANT_W;
    localparam int RES_W  = $clog2(NW) + FRAC_W;
    localparam int OFS_W  = $clog2(2 * SAMPLE_BITS - 1) + FRAC_W;
    localparam int D_W    = ((RES_W > OFS_W) ? RES_W : OFS_W) + 2;
    localparam int MAG_W  = D_W - 1;
    localparam int PRD_W  = K_W + MAG_W;
    localparam int R_W    = PRD_W + 1 - ROUND_SHIFT;
    localparam int OFS_Q16 = (2 * SAMPLE_BITS - 2) * (2 ** FRAC_W);
    localparam logic [PRD_W:0] HALF =
        {{(PRD_W - ROUND_SHIFT + 1){1'b0}}, 1'b1, {(ROUND_SHIFT - 1){1'b0}}};

    localparam logic [1:0] LV_IDLE = 2'd0;
    localparam logic [1:0] LV_LOGN = 2'd1;
    localparam logic [1:0] LV_LOGS = 2'd2;
    localparam logic [1:0] LV_MUL  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic               done_reg, done_next;
    logic [SUM_W-1:0]   sum_hold_reg, sum_hold_next;
    logic [RES_W-1:0]   ln_reg, ln_next;
    logic [LEVEL_W-1:0] level_reg, level_next;

    logic [SUM_W-1:0] log_x;
    logic             log_start, log_done;
    logic [RES_W-1:0] log_res;
    logic [D_W-1:0]   d_val;
    logic [MAG_W-1:0] d_mag;
    logic             mul_start, mul_done;
    logic [PRD_W-1:0] prod;
    logic [PRD_W:0]   rnd;
    logic [R_W-1:0]   r_val;

    // the first log takes n straight from the port, the second the held sum
    assign log_x = (state_reg == LV_IDLE) ? SUM_W'(count) : sum_hold_reg;

    frl_log2 #(
        .XW (SUM_W)
    ) u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (log_x),
        .done   (log_done),
        .result (log_res)
    );

    assign d_val = D_W'(log_res) - D_W'(ln_reg) - D_W'(OFS_Q16);
    assign d_mag = MAG_W'(~d_val + 1'b1);

    frl_smul #(
        .AW (K_W),
        .BW (MAG_W)
    ) u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (TEN_LOG10_2_Q24),
        .b     (d_mag),
        .done  (mul_done),
        .p     (prod)
    );

    assign rnd   = {1'b0, prod} + HALF;
    assign r_val = rnd[PRD_W:ROUND_SHIFT];

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        sum_hold_next = sum_hold_reg;
        ln_next       = ln_reg;
        level_next    = level_reg;
        log_start     = 1'b0;
        mul_start     = 1'b0;
        unique case (state_reg)
            LV_IDLE:
            begin
                if (start)
                begin
                    sum_hold_next = sum;
                    if (sum == '0)
                    begin
                        level_next = LEVEL_FLOOR;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        log_start  = 1'b1;
                        state_next = LV_LOGN;
                    end
                end
            end
            LV_LOGN:
            begin
                if (log_done)
                begin
                    ln_next    = log_res;
                    log_start  = 1'b1;
                    state_next = LV_LOGS;
                end
            end
            LV_LOGS:
            begin
                if (log_done)
                begin
                    // a non-negative difference rounds to zero dB or above: clamp to 0
                    if (!d_val[D_W-1])
                    begin
                        level_next = LEVEL_CEIL;
                        done_next  = 1'b1;
                        state_next = LV_IDLE;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        state_next = LV_MUL;
                    end
                end
            end
            LV_MUL:
            begin
                if (mul_done)
                begin
                    if (r_val > R_W'(FLOOR_MAG))
                    begin
                        level_next = LEVEL_FLOOR;
                    end
                    else
                    begin
                        level_next = ~LEVEL_W'(r_val) + 1'b1;
                    end
                    done_next  = 1'b1;
                    state_next = LV_IDLE;
                end
            end
            default:
            begin
                state_next = LV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_hold_reg <= sum_hold_next;
        ln_reg       <= ln_next;
        level_reg    <= level_next;
    end

    assign done  = done_reg;
    assign level = level_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/frame_rms_level_meter_top.sv -----
// ----------------------------------------------------------------------------
// Frame RMS level meter
// Sums sample squares per frame and reports the frame level in Q8.8 dBFS.
//
//   channel   dir   word                                    accepted when
//   samples   in    sample, end_of_frame                    valid && ready
//   levels    out   level_db, below_silence, frame_length   valid && ready
//   cfg       in    data -> silence threshold               valid && ready
//
// A sample is squared by the 4-bit digit-serial squarer. A closing sample adds two
// log2 passes on the shared unit and a digit-serial multiply for the dB scaling.
// A finished level waits in the output register; samples are accepted meanwhile.
// Reset clears the frame sum and count and loads the threshold with -70 dB.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_rms_level_meter_top
    import frl_pkg::*;
#(
    parameter int FRAME_LEN   = 512,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    frl_sample_if.sink  samples,
    frl_level_if.source levels,
    frl_cfg_if.sink     cfg
);

    localparam int SUM_W = 2 * SAMPLE_BITS - 1 + $clog2(FRAME_LEN);
    localparam int CNT_W = $clog2(FRAME_LEN + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(FRAME_LEN);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_LVL  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic                        eof_reg, eof_next;
    logic [CNT_W-1:0]            n_reg, n_next;
    logic signed [THRESH_W-1:0]  thr_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]          out_level_reg, out_level_next;
    logic                        out_below_reg, out_below_next;
    logic [FLEN_W-1:0]           out_len_reg, out_len_next;

    acc_ctrl_t          acc_ctrl;
    logic               acc_done;
    logic [SUM_W-1:0]   acc_sum;
    logic [CNT_W-1:0]   acc_count;
    logic               lvl_start, lvl_done;
    logic [LEVEL_W-1:0] lvl_level;
    logic               accept;

    frl_sqacc #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W)
    ) u_sqacc (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .sample (samples.sample),
        .done   (acc_done),
        .sum    (acc_sum),
        .count  (acc_count)
    );

    frl_level #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W)
    ) u_level (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lvl_start),
        .sum   (acc_sum),
        .count (acc_count),
        .done  (lvl_done),
        .level (lvl_level)
    );

    assign samples.ready = (state_reg == ST_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        eof_next       = eof_reg;
        n_next         = n_reg;
        acc_ctrl.start = accept;
        acc_ctrl.clear = 1'b0;
        lvl_start      = 1'b0;
        out_valid_next = out_valid_reg && !levels.ready;
        out_level_next = out_level_reg;
        out_below_next = out_below_reg;
        out_len_next   = out_len_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    eof_next   = samples.end_of_frame;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (acc_done)
                begin
                    if (eof_reg || (acc_count == FULL_COUNT))
                    begin
                        // hand sum and count over, then drop them for the next frame
                        lvl_start      = 1'b1;
                        acc_ctrl.clear = 1'b1;
                        n_next         = acc_count;
                        state_next     = ST_LVL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LVL:
            begin
                if (lvl_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || levels.ready)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = lvl_level;
                    out_below_next = $signed(lvl_level) < thr_reg;
                    out_len_next   = FLEN_W'(n_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            eof_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            thr_reg       <= THRESH_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            eof_reg       <= eof_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                thr_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        out_level_reg <= out_level_next;
        out_below_reg <= out_below_next;
        out_len_reg   <= out_len_next;
    end

    assign levels.valid         = out_valid_reg;
    assign levels.level_db      = out_level_reg;
    assign levels.below_silence = out_below_reg;
    assign levels.frame_length  = out_len_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/frl_checker.sv -----
// ----------------------------------------------------------------------------
// frl_checker
// Port-level checks of the level meter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_rms_level_meter_top_macros.svh"

module frl_checker
    import frl_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_ready,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic signed [LEVEL_W-1:0] level_db,
    input wire logic                      below_silence,
    input wire logic [FLEN_W-1:0]         frame_length
);

    // a stalled level word stays put
    `FRL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(level_db) && $stable(below_silence) && $stable(frame_length), "level word changed while stalled")

    // one sample at a time: ready drops right after an accepted word
    `FRL_ASSERT_NEXT(a_in_gap, in_valid && in_ready, !in_ready, "sample accepted while busy")

    // the reported level stays within the clamp range
    `FRL_ASSERT_NOW(a_level_range, out_valid, (level_db <= LEVEL_CEIL) && (level_db >= LEVEL_FLOOR), "level outside -120..0 dB")

endmodule

bind frame_rms_level_meter_top frl_checker u_frl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (samples.valid),
    .in_ready      (samples.ready),
    .out_valid     (levels.valid),
    .out_ready     (levels.ready),
    .level_db      (levels.level_db),
    .below_silence (levels.below_silence),
    .frame_length  (levels.frame_length)
);

`default_nettype wire
